// ===== src/gpba_pkg.sv =====
// ----------------------------------------------------------------------------
// gpba_pkg
// Shared types and codes for the grouped pool block allocator.
// ----------------------------------------------------------------------------
package gpba_pkg;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIND_IDLE,
        ST_LINK,
        ST_ALLOC_RD,
        ST_ALLOC_WR,
        ST_FREE_CHK,
        ST_FREE_WR,
        ST_ORD_FIND,
        ST_ORD_SHIFT,
        ST_ORD_PUT,
        ST_DONE
    } state_t;

    // what to do with the group order list once the item work is finished
    typedef enum logic [1:0] {
        ORD_NONE,
        ORD_TO_TAIL,
        ORD_TO_HEAD,
        ORD_DROP
    } ord_op_t;

endpackage

// ===== src/gpba_ram.sv =====
// ----------------------------------------------------------------------------
// gpba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/grouped_pool_block_allocator.sv =====
// ----------------------------------------------------------------------------
// grouped_pool_block_allocator
// Fixed-size block allocator over groups of items with LIFO free lists.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out; the block is busy in between. An
// allocation walks the group order list one entry a cycle, and when a fresh
// group is opened it searches for the lowest idle slot one a cycle and links
// its ITEMS_PER_GROUP items one a cycle through the link RAM write port; then
// a RAM read, a write and, when the group fills up, a move of the group to
// the tail. A free checks the handle, writes the link RAM and moves its group
// to the head of the order list, or drops the group from the list when its
// last item is freed and reclaim is enabled.
// Item next-links and allocated flags sit in RAMs; a group's flags are cleared
// while it is linked, so there is no clearing pass after reset.
module grouped_pool_block_allocator #(
    parameter int GROUP_SLOTS     = 8,
    parameter int ITEMS_PER_GROUP = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [6:0] handle_in
    input  logic        s_tuser,       // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [1:0] status, [8:2] handle_out, [16:9] blocks_in_use
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data       // reclaim_enable
);

    localparam int SW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int IW = $clog2(ITEMS_PER_GROUP);
    localparam int POOL = GROUP_SLOTS * ITEMS_PER_GROUP;
    localparam int PW = $clog2(POOL);
    localparam int CW = $clog2(ITEMS_PER_GROUP + 1);
    localparam int AW = $clog2(GROUP_SLOTS + 1);

    gpba_pkg::state_t state_reg, state_next;
    gpba_pkg::ord_op_t ord_reg, ord_next;

    logic                  reclaim_reg, reclaim_next;
    logic [GROUP_SLOTS-1:0] active_reg, active_next;
    logic [CW-1:0]         used_reg [GROUP_SLOTS];
    logic [CW-1:0]         used_next [GROUP_SLOTS];
    logic [IW-1:0]         head_reg [GROUP_SLOTS];
    logic [IW-1:0]         head_next [GROUP_SLOTS];
    logic [SW-1:0]         order_reg [GROUP_SLOTS];
    logic [SW-1:0]         order_next [GROUP_SLOTS];
    logic [AW-1:0]         acount_reg, acount_next;
    logic [7:0]            total_reg, total_next;

    logic [6:0]            hin_reg, hin_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [IW-1:0]         item_reg, item_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [1:0]            status_reg, status_next;
    logic [6:0]            hout_reg, hout_next;

    // link RAM
    logic          ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [IW-1:0] ram_wdata, ram_rdata;

    // allocated-flag RAM, shares the write address with the link RAM
    logic          flag_we;
    logic          flag_wdata;
    logic          flag_rdata;
    logic [PW-1:0] flag_raddr;

    gpba_ram #(.WIDTH(IW), .DEPTH(POOL)) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gpba_ram #(.WIDTH(1), .DEPTH(POOL)) u_flag_ram (
        .aclk  (aclk),
        .we    (flag_we),
        .waddr (ram_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    logic [PW-1:0] cur_h;
    logic [6:0]    hin_slot_wide;
    logic [SW-1:0] pos_sel;
    logic [SW-1:0] ord_at_pos;

    assign cur_h = PW'(slot_reg) * PW'(ITEMS_PER_GROUP) + PW'(item_reg);
    assign hin_slot_wide = hin_reg >> IW;
    assign pos_sel = pos_reg[SW-1:0];
    assign ord_at_pos = order_reg[pos_sel];

    assign s_tready  = (state_reg == gpba_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == gpba_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == gpba_pkg::ST_DONE);
    assign m_tdata   = {7'd0, total_reg, hout_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gpba_pkg::ST_IDLE;
            reclaim_reg <= 1'b1;
            active_reg  <= '0;
            acount_reg  <= '0;
            total_reg   <= '0;
            for (int g = 0; g < GROUP_SLOTS; g++) begin
                used_reg[g] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            reclaim_reg <= reclaim_next;
            active_reg  <= active_next;
            acount_reg  <= acount_next;
            total_reg   <= total_next;
            used_reg    <= used_next;
        end
        head_reg   <= head_next;
        order_reg  <= order_next;
        ord_reg    <= ord_next;
        hin_reg    <= hin_next;
        slot_reg   <= slot_next;
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
    end

    always_comb begin
        state_next   = state_reg;
        reclaim_next = reclaim_reg;
        active_next  = active_reg;
        used_next    = used_reg;
        head_next    = head_reg;
        order_next   = order_reg;
        acount_next  = acount_reg;
        total_next   = total_reg;
        ord_next     = ord_reg;
        hin_next     = hin_reg;
        slot_next    = slot_reg;
        item_next    = item_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        hout_next    = hout_reg;
        ram_we       = 1'b0;
        ram_waddr    = cur_h;
        ram_wdata    = '0;
        ram_raddr    = cur_h;
        flag_we      = 1'b0;
        flag_wdata   = 1'b0;
        flag_raddr   = hin_reg[PW-1:0];

        case (state_reg)
            gpba_pkg::ST_IDLE: begin
                // flag of the incoming handle is ready in the check state
                flag_raddr = s_tdata[PW-1:0];
                if (cfg_valid) begin
                    reclaim_next = cfg_data;
                end
                if (s_tvalid) begin
                    hin_next    = s_tdata[6:0];
                    pos_next    = '0;
                    hout_next   = '0;
                    status_next = gpba_pkg::STATUS_OK;
                    ord_next    = gpba_pkg::ORD_NONE;
                    state_next  = (s_tuser == gpba_pkg::MODE_FREE) ?
                                  gpba_pkg::ST_FREE_CHK : gpba_pkg::ST_SCAN;
                end
            end

            // one order entry per cycle
            gpba_pkg::ST_SCAN: begin
                if (pos_reg >= acount_reg) begin
                    pos_next   = '0;
                    state_next = gpba_pkg::ST_FIND_IDLE;
                end else if (used_reg[ord_at_pos] < CW'(ITEMS_PER_GROUP)) begin
                    slot_next  = ord_at_pos;
                    item_next  = head_reg[ord_at_pos];
                    state_next = gpba_pkg::ST_ALLOC_RD;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            // one slot per cycle, lowest idle first
            gpba_pkg::ST_FIND_IDLE: begin
                if (pos_reg >= AW'(GROUP_SLOTS)) begin
                    status_next = gpba_pkg::STATUS_NOSPACE;
                    state_next  = gpba_pkg::ST_DONE;
                end else if (!active_reg[pos_sel]) begin
                    slot_next   = pos_sel;
                    item_next   = '0;
                    active_next[pos_sel] = 1'b1;
                    used_next[pos_sel]   = '0;
                    head_next[pos_sel]   = '0;
                    // push at head
                    for (int g = 1; g < GROUP_SLOTS; g++) begin
                        order_next[g] = order_reg[g-1];
                    end
                    order_next[0] = pos_sel;
                    acount_next   = acount_reg + 1'b1;
                    state_next    = gpba_pkg::ST_LINK;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            gpba_pkg::ST_LINK: begin
                ram_we    = 1'b1;
                ram_wdata = (item_reg == IW'(ITEMS_PER_GROUP - 1)) ? '0 : item_reg + 1'b1;
                flag_we   = 1'b1;
                if (item_reg == IW'(ITEMS_PER_GROUP - 1)) begin
                    item_next  = '0;
                    state_next = gpba_pkg::ST_ALLOC_RD;
                end else begin
                    item_next = item_reg + 1'b1;
                end
            end

            // RAM read issued here, data valid next cycle
            gpba_pkg::ST_ALLOC_RD: begin
                state_next = gpba_pkg::ST_ALLOC_WR;
            end

            gpba_pkg::ST_ALLOC_WR: begin
                head_next[slot_reg] = ram_rdata;
                flag_we             = 1'b1;
                flag_wdata          = 1'b1;
                used_next[slot_reg] = used_reg[slot_reg] + 1'b1;
                total_next          = total_reg + 1'b1;
                hout_next           = 7'(cur_h);
                pos_next            = '0;
                if (used_reg[slot_reg] == CW'(ITEMS_PER_GROUP - 1) &&
                        order_reg[SW'(acount_reg - 1'b1)] != slot_reg) begin
                    ord_next   = gpba_pkg::ORD_TO_TAIL;
                    state_next = gpba_pkg::ST_ORD_FIND;
                end else begin
                    state_next = gpba_pkg::ST_DONE;
                end
            end

            gpba_pkg::ST_FREE_CHK: begin
                slot_next = hin_slot_wide[SW-1:0];
                item_next = hin_reg[IW-1:0];
                if (hin_slot_wide >= 7'(GROUP_SLOTS) ||
                        !active_reg[hin_slot_wide[SW-1:0]] ||
                        !flag_rdata) begin
                    status_next = gpba_pkg::STATUS_INVALID;
                    state_next  = gpba_pkg::ST_DONE;
                end else begin
                    state_next = gpba_pkg::ST_FREE_WR;
                end
            end

            gpba_pkg::ST_FREE_WR: begin
                ram_we              = 1'b1;
                ram_wdata           = head_reg[slot_reg];
                head_next[slot_reg] = item_reg;
                flag_we             = 1'b1;
                used_next[slot_reg] = used_reg[slot_reg] - 1'b1;
                total_next          = total_reg - 1'b1;
                pos_next            = '0;
                if (used_reg[slot_reg] == CW'(1) && reclaim_reg) begin
                    active_next[slot_reg] = 1'b0;
                    ord_next   = gpba_pkg::ORD_DROP;
                    state_next = gpba_pkg::ST_ORD_FIND;
                end else if (order_reg[0] != slot_reg) begin
                    ord_next   = gpba_pkg::ORD_TO_HEAD;
                    state_next = gpba_pkg::ST_ORD_FIND;
                end else begin
                    state_next = gpba_pkg::ST_DONE;
                end
            end

            gpba_pkg::ST_ORD_FIND: begin
                if (pos_reg >= acount_reg) begin
                    state_next = gpba_pkg::ST_DONE;
                end else if (ord_at_pos == slot_reg) begin
                    state_next = gpba_pkg::ST_ORD_SHIFT;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            // close the gap one entry per cycle
            gpba_pkg::ST_ORD_SHIFT: begin
                if (pos_reg + 1'b1 >= acount_reg) begin
                    acount_next = acount_reg - 1'b1;
                    pos_next    = acount_reg - 1'b1;
                    state_next  = (ord_reg == gpba_pkg::ORD_DROP) ?
                                  gpba_pkg::ST_DONE : gpba_pkg::ST_ORD_PUT;
                end else begin
                    order_next[pos_sel] = order_reg[SW'(pos_reg + 1'b1)];
                    pos_next = pos_reg + 1'b1;
                end
            end

            gpba_pkg::ST_ORD_PUT: begin
                if (ord_reg == gpba_pkg::ORD_TO_TAIL) begin
                    order_next[pos_sel] = slot_reg;
                    acount_next = acount_reg + 1'b1;
                    state_next  = gpba_pkg::ST_DONE;
                end else if (pos_reg == '0) begin
                    order_next[0] = slot_reg;
                    acount_next   = acount_reg + 1'b1;
                    state_next    = gpba_pkg::ST_DONE;
                end else begin
                    order_next[pos_sel] = order_reg[SW'(pos_reg - 1'b1)];
                    pos_next = pos_reg - 1'b1;
                end
            end

            gpba_pkg::ST_DONE: begin
                if (m_tready) begin
                    state_next = gpba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gpba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_grouped_pool_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_pool_block_allocator
// Self-checking bench: drives allocations and frees with random gaps and
// back-pressure, predicts each result with a behavioural pool model.
// ----------------------------------------------------------------------------
module tb_grouped_pool_block_allocator;

    localparam int NG = 8;
    localparam int NI = 16;
    localparam int NP = NG * NI;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [7:0] in_use;
        logic [6:0] handle;
        logic [1:0] status;
    } alloc_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    grouped_pool_block_allocator #(.GROUP_SLOTS(NG), .ITEMS_PER_GROUP(NI)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // pool model
    logic       reclaim;
    logic       g_act [NG];
    int         g_used [NG];
    int         g_head [NG];
    int         link [NP];
    logic       alloc_d [NP];
    int         order [NG];
    int         n_act;
    int         in_use;

    alloc_res_t pending_results [$];
    int         errors = 0;
    logic       quiet = 1'b0;
    int         idle_cnt = 0;

    function automatic int order_pos(int s);
        for (int p = 0; p < n_act; p++)
            if (order[p] == s) return p;
        return n_act;
    endfunction

    function automatic void order_drop(int s);
        int p;
        p = order_pos(s);
        if (p >= n_act) return;
        while (p + 1 < n_act) begin
            order[p] = order[p + 1];
            p++;
        end
        n_act--;
    endfunction

    function automatic void order_head(int s);
        if (n_act >= NG) return;
        for (int p = n_act; p > 0; p--) order[p] = order[p - 1];
        order[0] = s;
        n_act++;
    endfunction

    function automatic void pool_reset();
        reclaim = 1'b1;
        for (int i = 0; i < NG; i++) begin
            g_act[i] = 0; g_used[i] = 0; g_head[i] = 0; order[i] = 0;
        end
        for (int i = 0; i < NP; i++) begin
            link[i] = 0; alloc_d[i] = 0;
        end
        n_act = 0;
        in_use = 0;
    endfunction

    function automatic alloc_res_t pool_apply(logic mode, logic [6:0] h);
        alloc_res_t r;
        int s, it, i;
        logic found;
        r = '0;
        if (mode == gpba_pkg::MODE_ALLOC) begin
            found = 0;
            s = NG;
            for (int p = 0; p < n_act; p++)
                if (!found && g_used[order[p]] < NI) begin
                    s = order[p]; found = 1;
                end
            if (!found) begin
                for (i = 0; i < NG; i++) if (!g_act[i]) break;
                if (i >= NG) begin
                    r.status = gpba_pkg::STATUS_NOSPACE;
                    r.in_use = in_use[7:0];
                    return r;
                end
                s = i;
                g_act[s] = 1; g_used[s] = 0; g_head[s] = 0;
                for (i = 0; i < NI; i++) link[s * NI + i] = (i + 1 < NI) ? i + 1 : 0;
                order_head(s);
            end
            it = g_head[s] % NI;
            g_head[s] = link[s * NI + it];
            alloc_d[s * NI + it] = 1;
            g_used[s]++;
            in_use++;
            r.status = gpba_pkg::STATUS_OK;
            r.handle = 7'(s * NI + it);
            if (g_used[s] == NI && n_act > 0 && order[n_act - 1] != s) begin
                order_drop(s);
                if (n_act < NG) begin order[n_act] = s; n_act++; end
            end
        end else begin
            s = h / NI;
            it = h % NI;
            if (s >= NG || !g_act[s] || !alloc_d[h]) begin
                r.status = gpba_pkg::STATUS_INVALID;
            end else begin
                link[h] = g_head[s];
                g_head[s] = it;
                alloc_d[h] = 0;
                if (g_used[s] > 0) g_used[s]--;
                if (in_use > 0) in_use--;
                if (g_used[s] == 0 && reclaim) begin
                    order_drop(s);
                    g_act[s] = 0;
                end else if (n_act > 0 && order[0] != s) begin
                    order_drop(s);
                    order_head(s);
                end
                r.status = gpba_pkg::STATUS_OK;
            end
        end
        r.in_use = in_use[7:0];
        return r;
    endfunction

    task automatic random_gap();
        int n;
        if (!quiet && $urandom_range(3) == 0) begin
            n = $urandom_range(14, 1);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // tvalid stays up after a transfer; a drain or a random gap before the next send drops it
    task automatic send_op(logic mode, logic [6:0] h);
        random_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, h};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(pool_apply(mode, h));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reclaim(logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reclaim = v;
    endtask

    // pick a handle: mostly a live one, sometimes anything
    function automatic logic [6:0] pick_handle();
        int k;
        if ($urandom_range(9) < 8 && in_use > 0) begin
            k = $urandom_range(in_use - 1);
            for (int i = 0; i < NP; i++)
                if (alloc_d[i]) begin
                    if (k == 0) return 7'(i);
                    k--;
                end
        end
        return 7'($urandom_range(127));
    endfunction

    task automatic test_directed();
        send_op(gpba_pkg::MODE_FREE, 7'd0);       // free in an idle group
        send_op(gpba_pkg::MODE_ALLOC, 7'h7f);
        send_op(gpba_pkg::MODE_ALLOC, 7'h00);
        send_op(gpba_pkg::MODE_FREE, 7'd1);
        send_op(gpba_pkg::MODE_FREE, 7'd1);       // double free
        send_op(gpba_pkg::MODE_FREE, 7'd127);     // idle top group
        send_op(gpba_pkg::MODE_FREE, 7'd0);       // last item, group released
        send_op(gpba_pkg::MODE_ALLOC, 7'h55);
        send_op(gpba_pkg::MODE_FREE, 7'h2a);
    endtask

    task automatic test_fill_pool();
        for (int i = 0; i < NP + 3; i++)
            send_op(gpba_pkg::MODE_ALLOC, 7'($urandom_range(127)));
        send_op(gpba_pkg::MODE_FREE, 7'd127);
        send_op(gpba_pkg::MODE_FREE, 7'd64);
        send_op(gpba_pkg::MODE_ALLOC, 7'd0);
        send_op(gpba_pkg::MODE_ALLOC, 7'd0);
        send_op(gpba_pkg::MODE_ALLOC, 7'd0);      // no space again
    endtask

    task automatic test_random(int n, int alloc_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < alloc_pct)
                send_op(gpba_pkg::MODE_ALLOC, 7'($urandom_range(127)));
            else send_op(gpba_pkg::MODE_FREE, pick_handle());
        end
    endtask

    task automatic test_drain_all();
        for (int i = 0; i < NP && in_use > 0; i++) send_op(gpba_pkg::MODE_FREE, pick_handle());
    endtask

    // result checker and back-pressure
    always @(posedge aclk) begin
        alloc_res_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[16:0];
            if (pending_results.size() == 0) begin
                $error("result with none expected: %h", m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.handle !== want.handle) begin
                    $error("handle_out expected %0d actual %0d", want.handle, got.handle);
                    errors++;
                end
                if (got.in_use !== want.in_use) begin
                    $error("blocks_in_use expected %0d actual %0d", want.in_use, got.in_use);
                    errors++;
                end
            end
        end
        if (quiet) m_tready <= 1'b1;
        else if (idle_cnt > 0) begin
            idle_cnt <= idle_cnt - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(4) == 0) begin
            idle_cnt <= $urandom_range(14, 1) - 1;
            m_tready <= 1'b0;
        end else m_tready <= 1'b1;
    end

    // watchdog on transfer-free cycles
    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        pool_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_pool();
        test_drain_all();
        write_reclaim(1'b0);
        test_random(200, 60);
        test_drain_all();               // groups stay active with reclaim off
        write_reclaim(1'b1);
        test_random(200, 55);
        drain();                        // sender holds until all results are back
        write_reclaim(1'b0);
        test_random(100, 75);
        write_reclaim(1'b1);
        quiet = 1'b1;
        test_random(100, 50);
        drain();
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
